// ----- hw/rtl/bfha_pkg.sv -----
// Shared types and constants for the best-fit heap allocator.
package bfha_pkg;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StBadHeap  = 2'd2;
  localparam logic [1:0] StOverflow = 2'd3;

  localparam logic ModeAlloc = 1'b0;
  localparam logic ModeFree  = 1'b1;

  // APB byte address of the initial heap size register
  localparam logic [1:0] RegInitHeapSize = 2'd0;

  localparam logic [31:0] InitHeapReset = 32'd5242880;

  typedef struct packed {
    logic        mode;
    logic [31:0] req_size;
    logic [3:0]  blk_heap;
    logic [31:0] blk_offset;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  out_heap;
    logic [31:0] out_offset;
    logic [31:0] out_size;
    logic        heap_opened;
    logic [31:0] opened_size;
  } rsp_t;

  // Saturating doubling of a heap size.
  function automatic logic [31:0] sat_double(input logic [31:0] v);
    sat_double = v[31] ? 32'hFFFF_FFFF : {v[30:0], 1'b0};
  endfunction

endpackage

// ----- hw/rtl/bfha_if.sv -----
// Valid/ready channel carrying a request or a response.
interface bfha_if #(
  parameter int unsigned W = 1
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/bfha_table.sv -----
// Free-block table: offset and size memories with registered read.
module bfha_table #(
  parameter int unsigned AW = 9
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [31:0]   woff_i,
  input  logic [31:0]   wsize_i,
  input  logic [AW-1:0] raddr_i,
  output logic [31:0]   roff_o,
  output logic [31:0]   rsize_o
);

  logic [31:0] off_mem  [2**AW];
  logic [31:0] size_mem [2**AW];

  // Single write port, single read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      off_mem[waddr_i]  <= woff_i;
      size_mem[waddr_i] <= wsize_i;
    end
    roff_o  <= off_mem[raddr_i];
    rsize_o <= size_mem[raddr_i];
  end

endmodule

// ----- hw/rtl/best_fit_heap_allocator.sv -----
// Top level of the best-fit heap allocator: control sequencer and heap marks.
//
// Usage: requests enter on req (mode, req_size, blk_heap, blk_offset); one
// response per request leaves on rsp. Register initial_heap_size is written
// over the APB port at address 0 while the block is idle.
// Heap 0 opens on the first request after reset using initial_heap_size.
// Each request is handled alone by a sequencer around one free-table memory
// (one read port, registered read data). An allocate takes a pass over the
// heap marks, then either opens a new heap or takes one pass over the chosen
// heap's table to find the best fit; then comes a write and a second pass to
// recompute the largest free size. A free takes one neighbour search pass,
// one or two writes and the recompute pass.
// Reset clears the heap count and the per-heap entry counts; the table
// memory is not cleared, since only entries below a heap's count are read.
// A response waits in an output register while the receiver stalls; the
// next request is taken once the response has been handed over.
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int unsigned MAX_HEAPS        = 16,
  parameter int unsigned MAX_FREE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bfha_if.sink        req,
  bfha_if.source      rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned HW  = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
  localparam int unsigned EW  = (MAX_FREE_ENTRIES > 1) ? $clog2(MAX_FREE_ENTRIES) : 1;
  localparam int unsigned CW  = $clog2(MAX_FREE_ENTRIES + 1);
  localparam int unsigned HCW = $clog2(MAX_HEAPS + 1);
  localparam int unsigned AW  = HW + EW;

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_HSCAN  = 12'b000000000010,
    S_FSCAN  = 12'b000000000100,
    S_FWAIT  = 12'b000000001000,
    S_ALAST  = 12'b000000010000,
    S_AWR    = 12'b000000100000,
    S_RSCAN  = 12'b000001000000,
    S_RWAIT  = 12'b000010000000,
    S_FRWAIT = 12'b000100000000,
    S_FRDEC  = 12'b001000000000,
    S_FRLAST = 12'b010000000000,
    S_OUT    = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // Configuration register
  logic [31:0] init_size_q;
  assign pready = 1'b1;
  assign prdata = (paddr == RegInitHeapSize) ? init_size_q : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_size_q <= InitHeapReset;
    end else if (psel && penable && pwrite && paddr == RegInitHeapSize) begin
      init_size_q <= pwdata;
    end
  end

  // Heap marks and counts (small, flip-flops)
  logic [31:0]  largest_q [MAX_HEAPS];
  logic [CW-1:0] cnt_q    [MAX_HEAPS];
  logic [HCW-1:0] heap_count_q;
  logic [31:0]  next_bytes_q;

  // Request capture
  req_t        r_q;
  rsp_t        out_q;
  logic        out_valid_q;

  // Scan state
  logic [EW:0]   idx_q;      // table index being issued
  logic [EW:0]   ridx_q;     // index of data arriving
  logic [HCW-1:0] hidx_q;
  logic          sel_ok_q;
  logic [HW-1:0] sel_q;
  logic          best_ok_q;
  logic [EW-1:0] best_q;
  logic [31:0]   best_size_q, best_off_q;
  logic [31:0]   acc_q;
  logic          bef_ok_q, aft_ok_q;
  logic [EW-1:0] bef_q, aft_q;
  logic [31:0]   bef_size_q, aft_size_q;
  logic [31:0]   last_off_q, last_size_q;
  logic [1:0]    wstep_q;

  // Table memory ports
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   woff, wsize, roff, rsize;

  logic [CW-1:0] n;
  assign n = cnt_q[sel_q];
  logic [EW-1:0] last;
  assign last = EW'(n - CW'(1));

  assign req.ready = (state_q == S_IDLE) && !out_valid_q;
  assign rsp.valid = out_valid_q;
  assign rsp.data  = out_q;

  logic [32:0] end_off;
  assign end_off = {1'b0, r_q.blk_offset} + {1'b0, r_q.req_size};
  logic [32:0] ent_end;
  assign ent_end = {1'b0, roff} + {1'b0, rsize};
  logic rvalid;   // data in roff/rsize belongs to entry ridx_q
  logic rvalid_q;
  assign rvalid = rvalid_q;

  logic [32:0] sum1;
  assign sum1 = {1'b0, bef_ok_q ? bef_size_q : aft_size_q} + {1'b0, r_q.req_size};
  logic [33:0] sum2;
  assign sum2 = {1'b0, sum1} + {2'b0, aft_size_q};

  always_comb begin
    raddr = {sel_q, idx_q[EW-1:0]};
    we    = 1'b0;
    waddr = {sel_q, best_q};
    woff  = 32'd0;
    wsize = 32'd0;
    if (state_q == S_AWR) begin
      we = 1'b1;
      if (best_size_q == r_q.req_size) begin
        woff  = last_off_q;
        wsize = last_size_q;
      end else begin
        woff  = best_off_q + r_q.req_size;
        wsize = best_size_q - r_q.req_size;
      end
    end
    if (state_q == S_FRDEC) begin
      case (wstep_q)
        2'd0: begin
          we = 1'b1;
          if (bef_ok_q) begin
            waddr = {sel_q, bef_q};
            woff  = best_off_q;
            wsize = aft_ok_q ? sum2[31:0] : sum1[31:0];
          end else if (aft_ok_q) begin
            waddr = {sel_q, aft_q};
            woff  = r_q.blk_offset;
            wsize = sum1[31:0];
          end else begin
            waddr = {sel_q, n[EW-1:0]};
            woff  = r_q.blk_offset;
            wsize = r_q.req_size;
          end
        end
        default: begin
          // last entry fills the after-slot; if it was the merged entry, take its new size
          we    = 1'b1;
          waddr = {sel_q, aft_q};
          woff  = last_off_q;
          wsize = (bef_q == last) ? sum2[31:0] : last_size_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req.valid && req.ready) begin
      r_q <= req.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      heap_count_q <= '0;
      next_bytes_q <= '0;
      out_valid_q  <= 1'b0;
      rvalid_q     <= 1'b0;
      for (int h = 0; h < MAX_HEAPS; h++) cnt_q[h] <= '0;
    end else begin
      rvalid_q <= 1'b0;
      if (out_valid_q && rsp.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            out_q <= '0;
            if (heap_count_q == '0) begin
              heap_count_q <= HCW'(1);
              cnt_q[0]     <= CW'(1);
              largest_q[0] <= init_size_q;
              next_bytes_q <= sat_double(init_size_q);
              // heap 0 entry goes through the one-shot write below
            end
            hidx_q   <= '0;
            sel_ok_q <= 1'b0;
            sel_q    <= '0;
            state_q  <= S_HSCAN;
          end
        end
        S_HSCAN: begin
          // a just-opened heap 0 gets its first entry written in this cycle
          if (r_q.mode == ModeFree) begin
            if (32'(r_q.blk_heap) >= 32'(heap_count_q)) begin
              out_q.status <= StBadHeap;
              out_valid_q  <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              sel_q    <= HW'(r_q.blk_heap);
              idx_q    <= '0;
              bef_ok_q <= 1'b0;
              aft_ok_q <= 1'b0;
              state_q  <= S_FRWAIT;
            end
          end else if (hidx_q < heap_count_q) begin
            if (cnt_q[hidx_q[HW-1:0]] != '0 &&
                largest_q[hidx_q[HW-1:0]] >= r_q.req_size &&
                (!sel_ok_q || largest_q[sel_q] > largest_q[hidx_q[HW-1:0]])) begin
              sel_ok_q <= 1'b1;
              sel_q    <= hidx_q[HW-1:0];
            end
            hidx_q <= hidx_q + HCW'(1);
          end else if (!sel_ok_q) begin
            if (heap_count_q >= HCW'(MAX_HEAPS)) begin
              out_q.status <= StFull;
              out_valid_q  <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              logic [31:0] bytes;
              logic [31:0] dbl;
              bytes = (next_bytes_q > r_q.req_size) ? next_bytes_q : r_q.req_size;
              dbl   = sat_double(next_bytes_q);
              sel_q <= HW'(heap_count_q);
              cnt_q[HW'(heap_count_q)]     <= CW'(1);
              largest_q[HW'(heap_count_q)] <= bytes;
              heap_count_q <= heap_count_q + HCW'(1);
              next_bytes_q <= (r_q.req_size > dbl) ? r_q.req_size : dbl;
              out_q.heap_opened <= 1'b1;
              out_q.opened_size <= bytes;
              // fresh heap: single entry at offset 0, fits by construction
              best_ok_q   <= 1'b1;
              best_q      <= '0;
              best_off_q  <= 32'd0;
              best_size_q <= bytes;
              last_off_q  <= 32'd0;
              last_size_q <= bytes;
              state_q     <= S_AWR;
            end
          end else begin
            idx_q     <= '0;
            best_ok_q <= 1'b0;
            state_q   <= S_FSCAN;
          end
        end
        // Best-fit pass over the chosen heap's table
        S_FSCAN: begin
          if (idx_q < (EW+1)'(n)) begin
            rvalid_q <= 1'b1;
            ridx_q   <= idx_q;
            idx_q    <= idx_q + (EW+1)'(1);
          end else begin
            state_q <= S_FWAIT;
          end
          if (rvalid && rsize >= r_q.req_size &&
              (!best_ok_q || best_size_q > rsize)) begin
            best_ok_q   <= 1'b1;
            best_q      <= ridx_q[EW-1:0];
            best_size_q <= rsize;
            best_off_q  <= roff;
          end
          if (rvalid && ridx_q[EW-1:0] == last) begin
            last_off_q  <= roff;
            last_size_q <= rsize;
          end
        end
        S_FWAIT: begin
          if (rvalid && rsize >= r_q.req_size &&
              (!best_ok_q || best_size_q > rsize)) begin
            best_ok_q   <= 1'b1;
            best_q      <= ridx_q[EW-1:0];
            best_size_q <= rsize;
            best_off_q  <= roff;
          end
          if (rvalid && ridx_q[EW-1:0] == last) begin
            last_off_q  <= roff;
            last_size_q <= rsize;
          end
          state_q <= S_ALAST;
        end
        S_ALAST: begin
          if (!best_ok_q) begin
            out_q.status <= StFull;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_AWR;
          end
        end
        S_AWR: begin
          out_q.out_heap   <= 4'(sel_q);
          out_q.out_offset <= best_off_q;
          out_q.out_size   <= r_q.req_size;
          if (best_size_q == r_q.req_size) cnt_q[sel_q] <= n - CW'(1);
          idx_q   <= '0;
          acc_q   <= '0;
          state_q <= S_RSCAN;
        end
        // Recompute the largest free size
        S_RSCAN: begin
          if (idx_q < (EW+1)'(n)) begin
            rvalid_q <= 1'b1;
            idx_q    <= idx_q + (EW+1)'(1);
          end else begin
            state_q <= S_RWAIT;
          end
          if (rvalid && rsize > acc_q) acc_q <= rsize;
        end
        S_RWAIT: begin
          largest_q[sel_q] <= (rvalid && rsize > acc_q) ? rsize : acc_q;
          state_q <= S_OUT;
        end
        S_OUT: begin
          out_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        // Neighbour search for a free
        S_FRWAIT: begin
          if (idx_q < (EW+1)'(n)) begin
            rvalid_q <= 1'b1;
            ridx_q   <= idx_q;
            idx_q    <= idx_q + (EW+1)'(1);
          end else if (!rvalid) begin
            state_q <= S_FRLAST;
          end
          if (rvalid) begin
            if (!bef_ok_q && ent_end == {1'b0, r_q.blk_offset}) begin
              bef_ok_q   <= 1'b1;
              bef_q      <= ridx_q[EW-1:0];
              bef_size_q <= rsize;
              best_off_q <= roff;
            end else if (!aft_ok_q && {1'b0, roff} == end_off) begin
              aft_ok_q   <= 1'b1;
              aft_q      <= ridx_q[EW-1:0];
              aft_size_q <= rsize;
            end
            if (ridx_q[EW-1:0] == last) begin
              last_off_q  <= roff;
              last_size_q <= rsize;
            end
          end
        end
        S_FRLAST: begin
          wstep_q <= 2'd0;
          if ((bef_ok_q && aft_ok_q && sum2[33:32] != 2'b00) ||
              ((bef_ok_q != aft_ok_q) && sum1[32])) begin
            out_q.status <= StOverflow;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else if (!bef_ok_q && !aft_ok_q && n >= CW'(MAX_FREE_ENTRIES)) begin
            out_q.status <= StFull;
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end else begin
            state_q <= S_FRDEC;
          end
        end
        S_FRDEC: begin
          if (wstep_q == 2'd0 && bef_ok_q && aft_ok_q) begin
            wstep_q <= 2'd1;
          end else begin
            if (bef_ok_q && aft_ok_q) cnt_q[sel_q] <= n - CW'(1);
            else if (!bef_ok_q && !aft_ok_q) cnt_q[sel_q] <= n + CW'(1);
            idx_q   <= '0;
            acc_q   <= '0;
            state_q <= S_RSCAN;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Heap 0 initial entry: written in the first HSCAN cycle after opening.
  // Done by a one-shot write muxed ahead of the table port.
  logic init_wr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) init_wr_q <= 1'b0;
    else init_wr_q <= (state_q == S_IDLE) && req.valid && req.ready &&
                      (heap_count_q == '0);
  end

  // The opening write uses the table port in HSCAN, where it is otherwise idle.
  logic          we_m;
  logic [AW-1:0] waddr_m;
  logic [31:0]   woff_m, wsize_m;
  assign we_m    = init_wr_q ? 1'b1 : we;
  assign waddr_m = init_wr_q ? '0 : waddr;
  assign woff_m  = init_wr_q ? 32'd0 : woff;
  assign wsize_m = init_wr_q ? init_size_q : wsize;

  bfha_table #(.AW(AW)) u_table (
    .clk_i  (clk_i),
    .we_i   (we_m),
    .waddr_i(waddr_m),
    .woff_i (woff_m),
    .wsize_i(wsize_m),
    .raddr_i(raddr),
    .roff_o (roff),
    .rsize_o(rsize)
  );

  // A response is never dropped while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
    else $error("response lost under stall");
  // No request accepted while a response is pending
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> !req.ready)
    else $error("request taken with pending response");
  // Heap count never exceeds the heap limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    heap_count_q <= HCW'(MAX_HEAPS))
    else $error("heap count overflow");

endmodule
